>>> hw/rtl/srt_pkg.sv
package srt_pkg;

   // command codes carried in req_tuser
   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_SET   = 3'd2;
   localparam logic [2:0] OP_NORM  = 3'd3;
   localparam logic [2:0] OP_SHIFT = 3'd4;
   localparam logic [2:0] OP_SCALE = 3'd5;
   localparam logic [2:0] OP_READ  = 3'd6;
   localparam logic [2:0] OP_QUERY = 3'd7;

   // response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic               scale_en;
      logic               shift_en;
      logic signed [31:0] base;
      logic signed [31:0] delta;
      logic [23:0]        factor;
   } xf_ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      logic signed [31:0] r;
      if (v > 58'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -58'sh0_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/srt_ram.sv
module srt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/srt_xform.sv
module srt_xform import srt_pkg::*; (
   input  logic               clock,
   input  xf_ctrl_type        ctrl,
   input  logic signed [31:0] x_s,
   input  logic signed [31:0] x_e,
   output logic signed [31:0] y_s,
   output logic signed [31:0] y_e
);

   // registered difference or sum, then registered partial products; floor and saturate are combinational
   logic signed [31:0] x_in   [2];
   logic signed [31:0] y_out  [2];
   logic signed [32:0] d1_ff  [2];
   logic signed [31:0] v1_ff  [2];
   logic signed [31:0] v2_ff  [2];
   logic signed [45:0] plo_ff [2];
   logic signed [45:0] phi_ff [2];
   logic               scale1_ff;
   logic               scale2_ff;
   logic signed [31:0] base1_ff;
   logic signed [31:0] base2_ff;

   assign x_in[0] = x_s;
   assign x_in[1] = x_e;
   assign y_s     = y_out[0];
   assign y_e     = y_out[1];

   always_ff @(posedge clock) begin
      scale1_ff <= ctrl.scale_en;
      scale2_ff <= scale1_ff;
      base1_ff  <= ctrl.base;
      base2_ff  <= base1_ff;
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic signed [32:0] sum1;
      logic signed [57:0] prod;
      logic signed [57:0] quot;
      logic signed [57:0] res;

      assign sum1 = {x_in[g][31], x_in[g]} + {ctrl.delta[31], ctrl.delta};

      always_ff @(posedge clock) begin
         d1_ff[g] <= {x_in[g][31], x_in[g]} - {ctrl.base[31], ctrl.base};
         if (ctrl.shift_en) begin
            v1_ff[g] <= sat32({{25{sum1[32]}}, sum1});
         end else begin
            v1_ff[g] <= x_in[g];
         end
         plo_ff[g] <= d1_ff[g] * $signed({1'b0, ctrl.factor[11:0]});
         phi_ff[g] <= d1_ff[g] * $signed({1'b0, ctrl.factor[23:12]});
         v2_ff[g]  <= v1_ff[g];
      end

      assign prod = {{12{plo_ff[g][45]}}, plo_ff[g]} + {phi_ff[g], 12'b0};
      assign quot = prod >>> 16;
      assign res  = quot + {{26{base2_ff[31]}}, base2_ff};
      assign y_out[g] = scale2_ff ? sat32(res) : v2_ff[g];
   end

endmodule

>>> hw/rtl/selection_region_table_core.sv
// Response: clear, read, query and an add on a full table answer straight from idle; add
//   and set run the insert step, an add moving each entry whose start is not smaller up
//   one place; normalise, translate and scale pass each entry through srt_xform and, when
//   the table is rewritten, clamp, merge and reinsert them; an empty table answers straight from idle.
// Throughput: one request at a time; a response still waiting holds the next one in S_DONE.
// Reset: entry count and clamp limit clear to zero; region memories keep their contents.
module selection_region_table_core import srt_pkg::*; #(
   parameter int MAX_REGIONS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // region_begin[31:0], region_finish[63:32], shift_amount[95:64],
   // scale_factor[119:96], entry_index[125:120], zero [127:126]
   input  logic [127:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], zero [7:2]
   output logic [7:0]   rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_XF_RD  = 4'd1;
   localparam logic [3:0] S_XF_W0  = 4'd2;
   localparam logic [3:0] S_XF_W1  = 4'd3;
   localparam logic [3:0] S_XF_W2  = 4'd4;
   localparam logic [3:0] S_XF_CHK = 4'd5;
   localparam logic [3:0] S_TD_RD  = 4'd6;
   localparam logic [3:0] S_TD_EV  = 4'd7;
   localparam logic [3:0] S_TD_NXT = 4'd8;
   localparam logic [3:0] S_TD_END = 4'd9;
   localparam logic [3:0] S_INS_RD = 4'd10;
   localparam logic [3:0] S_INS_CM = 4'd11;
   localparam logic [3:0] S_SETCNT = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   function automatic logic signed [31:0] clamp_fc(input logic signed [31:0] v,
                                                   input logic [30:0] fc);
      logic signed [31:0] fcs;
      logic signed [31:0] r;
      fcs = $signed({1'b0, fc});
      if (v < 0) begin
         r = '0;
      end else if (v > fcs) begin
         r = fcs;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [3:0]         state_ff, state_in;
   logic [3:0]         ret_ff, ret_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      nc_ff, nc_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] delta_ff, delta_in;
   logic [23:0]        factor_ff, factor_in;
   logic signed [31:0] base_ff, base_in;
   logic [30:0]        fc_ff, fc_in;
   logic signed [31:0] run_end_ff, run_end_in;
   logic               need_ff, need_in;
   logic signed [31:0] cs_ff, cs_in;
   logic signed [31:0] ce_ff, ce_in;
   logic signed [31:0] ins_a_ff, ins_a_in;
   logic signed [31:0] ins_b_ff, ins_b_in;
   logic [1:0]         st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] mem_ws;
   logic signed [31:0] mem_we_d;
   logic signed [31:0] rd_s;
   logic signed [31:0] rd_e;
   logic signed [31:0] xf_s;
   logic signed [31:0] xf_e;
   xf_ctrl_type        xf_ctrl;

   logic               accept;
   logic [CW-1:0]      last_idx;
   logic [CW-1:0]      k_dec;
   logic signed [31:0] cl_s;
   logic signed [31:0] cl_e;
   logic               out_rng;
   logic               need_nx;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign last_idx   = cnt_ff - 1'b1;
   assign k_dec      = k_ff - 1'b1;
   assign cl_s       = clamp_fc(rd_s, fc_ff);
   assign cl_e       = clamp_fc(rd_e, fc_ff);
   assign out_rng    = (xf_s < 0) || (xf_e > $signed({1'b0, fc_ff}));
   assign need_nx    = (i_ff == '0) ? out_rng
                     : (need_ff || out_rng || (run_end_ff >= xf_s));

   // base of the scale is the first start; take it straight from the memory on entry 0
   always_comb begin
      xf_ctrl.scale_en = (op_ff == OP_SCALE);
      xf_ctrl.shift_en = (op_ff == OP_SHIFT);
      xf_ctrl.base     = (state_ff == S_XF_W0 && i_ff == '0) ? rd_s : base_ff;
      xf_ctrl.delta    = delta_ff;
      xf_ctrl.factor   = factor_ff;
   end

   srt_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS)) u_start_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_ws),
      .rd_addr (mem_raddr),
      .rd_data (rd_s)
   );

   srt_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS)) u_end_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_we_d),
      .rd_addr (mem_raddr),
      .rd_data (rd_e)
   );

   srt_xform u_xform (
      .clock (clock),
      .ctrl  (xf_ctrl),
      .x_s   (rd_s),
      .x_e   (rd_e),
      .y_s   (xf_s),
      .y_e   (xf_e)
   );

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cnt_in        = cnt_ff;
      nc_in         = nc_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      op_in         = op_ff;
      delta_in      = delta_ff;
      factor_in     = factor_ff;
      base_in       = base_ff;
      fc_in         = csr_wr_en ? csr_wr_data : fc_ff;
      run_end_in    = run_end_ff;
      need_in       = need_ff;
      cs_in         = cs_ff;
      ce_in         = ce_ff;
      ins_a_in      = ins_a_ff;
      ins_b_in      = ins_b_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = k_ff[AW-1:0];
      mem_ws        = ins_a_ff;
      mem_we_d      = ins_b_ff;
      mem_raddr     = i_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               delta_in  = req_tdata[95:64];
               factor_in = req_tdata[119:96];
               st_in     = STAT_OK;
               i_in      = '0;
               ins_a_in  = req_tdata[31:0];
               ins_b_in  = req_tdata[63:32];
               ret_in    = S_SETCNT;
               state_in  = S_DONE;
               case (req_tuser)
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  OP_ADD: begin
                     if (cnt_ff == CW'(MAX_REGIONS)) begin
                        st_in = STAT_FULL;
                     end else begin
                        nc_in    = cnt_ff;
                        k_in     = cnt_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_SET: begin
                     nc_in    = '0;
                     k_in     = '0;
                     state_in = S_INS_RD;
                  end
                  OP_NORM, OP_SHIFT, OP_SCALE: begin
                     if (cnt_ff != '0) begin
                        state_in = S_XF_RD;
                     end
                  end
                  OP_READ: begin
                     if ({{CW{1'b0}}, req_tdata[125:120]} >= {6'b0, cnt_ff}) begin
                        st_in = STAT_RANGE;
                     end
                  end
                  default: begin
                     st_in = STAT_OK;
                  end
               endcase
            end
         end
         S_XF_RD: begin
            state_in = S_XF_W0;
         end
         S_XF_W0: begin
            base_in  = xf_ctrl.base;
            state_in = S_XF_W1;
         end
         S_XF_W1: begin
            state_in = S_XF_W2;
         end
         S_XF_W2: begin
            state_in = S_XF_CHK;
         end
         S_XF_CHK: begin
            // write back the moved region unless normalising, and fold it into the overlap check
            if (op_ff != OP_NORM) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff[AW-1:0];
               mem_ws    = xf_s;
               mem_we_d  = xf_e;
            end
            need_in = need_nx;
            if (i_ff == '0 || run_end_ff < xf_e) begin
               run_end_in = xf_e;
            end
            if (i_ff == last_idx) begin
               if (need_nx) begin
                  i_in     = '0;
                  nc_in    = '0;
                  state_in = S_TD_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_XF_RD;
            end
         end
         S_TD_RD: begin
            state_in = S_TD_EV;
         end
         S_TD_EV: begin
            state_in = S_TD_NXT;
            if (i_ff == '0) begin
               cs_in = cl_s;
               ce_in = cl_e;
            end else if (ce_ff >= cl_s) begin
               // merge into the current region; drop if fully absorbed
               if (!(ce_ff > cl_e)) begin
                  ce_in = cl_e;
               end
            end else begin
               cs_in = cl_s;
               ce_in = cl_e;
               if (cs_ff != ce_ff) begin
                  ins_a_in = cs_ff;
                  ins_b_in = ce_ff;
                  k_in     = nc_ff;
                  ret_in   = S_TD_NXT;
                  state_in = S_INS_RD;
               end
            end
         end
         S_TD_NXT: begin
            if (i_ff == last_idx) begin
               state_in = S_TD_END;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_TD_RD;
            end
         end
         S_TD_END: begin
            state_in = S_SETCNT;
            if (cs_ff != ce_ff) begin
               ins_a_in = cs_ff;
               ins_b_in = ce_ff;
               k_in     = nc_ff;
               ret_in   = S_SETCNT;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            // walk down from the top, shifting entries up until a smaller start
            if (k_ff == '0) begin
               mem_we   = 1'b1;
               nc_in    = nc_ff + 1'b1;
               state_in = ret_ff;
            end else begin
               mem_raddr = k_dec[AW-1:0];
               state_in  = S_INS_CM;
            end
         end
         S_INS_CM: begin
            mem_we = 1'b1;
            if (rd_s < ins_a_ff) begin
               nc_in    = nc_ff + 1'b1;
               state_in = ret_ff;
            end else begin
               mem_ws   = rd_s;
               mem_we_d = rd_e;
               k_in     = k_dec;
               state_in = S_INS_RD;
            end
         end
         S_SETCNT: begin
            cnt_in   = nc_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      nc_ff         <= nc_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      op_ff         <= op_in;
      delta_ff      <= delta_in;
      factor_ff     <= factor_in;
      base_ff       <= base_in;
      run_end_ff    <= run_end_in;
      need_ff       <= need_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      ins_a_ff      <= ins_a_in;
      ins_b_ff      <= ins_b_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff};

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_REGIONS))
      else $error("entry count beyond table size");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_RD || state_ff == S_INS_CM) |-> (nc_ff < CW'(MAX_REGIONS)))
      else $error("insert without room");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == OP_ADD && cnt_ff == CW'(MAX_REGIONS))
      |=> (st_ff == STAT_FULL && state_ff == S_DONE))
      else $error("add on full table not flagged");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");
`endif

endmodule
